>>> sv/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache tag check.
package dmc_pkg;

   // Field widths
   localparam int ADDR_FIELD_W = 32;
   localparam int LINE_FIELD_W = 10;
   localparam int COUNT_W      = 32;
   localparam int RSP_DATA_W   = 112;
   localparam int RSP_PAD_W    = RSP_DATA_W - LINE_FIELD_W - 3 * COUNT_W;

   // Defaults for top-level parameters
   localparam int MAX_LINES_DEF = 1024;
   localparam int ADDR_BITS_DEF = 32;

   // Configuration registers
   localparam int OFFSET_W     = 5;
   localparam int INDEX_W      = 4;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 5'd16;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd4;
   localparam logic [INDEX_W-1:0]  INDEX_RESET  = 4'd10;

   typedef enum logic {
      REG_OFFSET_WIDTH = 1'b0,
      REG_INDEX_WIDTH  = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_width;
      logic [INDEX_W-1:0]  index_width;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic clear;   // zero one store entry
      logic lookup;  // capture address, read store
      logic commit;  // compare, update store and counters, load result
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;  // final entry of the clearing pass
      logic out_free;    // result register can take a new transaction
   } ctrl_status_type;

endpackage

>>> sv/dmc_csr.sv
// Configuration register block with APB-style access.
module dmc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dmc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dmc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dmc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output dmc_pkg::cfg_type                cfg
);
   import dmc_pkg::*;

   logic [OFFSET_W-1:0] offset_width_ff;
   logic [INDEX_W-1:0]  index_width_ff;
   logic                wr_en;
   csr_reg_type         reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_width_ff <= OFFSET_RESET;
         index_width_ff  <= INDEX_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_OFFSET_WIDTH: offset_width_ff <= csr_pwdata[OFFSET_W-1:0];
            REG_INDEX_WIDTH:  index_width_ff  <= csr_pwdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_OFFSET_WIDTH: csr_prdata = CSR_DATA_W'(offset_width_ff);
         REG_INDEX_WIDTH:  csr_prdata = CSR_DATA_W'(index_width_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.offset_width = offset_width_ff;
   assign cfg.index_width  = index_width_ff;

endmodule

>>> sv/dmc_ctrl.sv
// Controller state machine: store clearing, lookup and commit sequencing.
module dmc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  dmc_pkg::ctrl_status_type status,
   output dmc_pkg::ctrl_cmd_type    cmd
);
   import dmc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // hold until the result register is free
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.lookup = req_tvalid;
         end
         ST_CHECK: begin
            cmd.commit = status.out_free;
         end
         default: ;
      endcase
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted transaction did not move to check");

endmodule

>>> sv/dmc_datapath.sv
// Datapath: address split, line store, counters and result register.
module dmc_datapath #(
   parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
   parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dmc_pkg::cfg_type                  cfg,
   input  dmc_pkg::ctrl_cmd_type             cmd,
   output dmc_pkg::ctrl_status_type          status,
   input  logic [dmc_pkg::ADDR_FIELD_W-1:0]  req_tdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [dmc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser
);
   import dmc_pkg::*;

   localparam int ADDR_W    = (ADDR_BITS < ADDR_FIELD_W) ? ADDR_BITS : ADDR_FIELD_W;
   localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int IDX_BOUND = $clog2(MAX_LINES + 1) - 1;
   localparam int SH_W      = OFFSET_W + 1;

   logic [ADDR_W:0] mem [MAX_LINES];

   logic [IDX_W-1:0]    clr_ff;
   logic [ADDR_W:0]     rd_ff;
   logic [IDX_W-1:0]    line_ff;
   logic [ADDR_W-1:0]   tag_ff;
   logic [COUNT_W-1:0]  access_ff;
   logic [COUNT_W-1:0]  hits_ff;
   logic [COUNT_W-1:0]  misses_ff;
   logic                rsp_tvalid_ff;
   logic                out_hit_ff;
   logic [IDX_W-1:0]    out_line_ff;

   logic [ADDR_W-1:0]   addr;
   logic [OFFSET_W-1:0] off;
   logic [OFFSET_W-1:0] idw;
   logic [ADDR_W-1:0]   shifted;
   logic [IDX_W-1:0]    idx_mask;
   logic [IDX_W-1:0]    line_in;
   logic [SH_W-1:0]     tag_sh;
   logic [ADDR_W-1:0]   tag_in;
   logic                hit_now;

   // Split the address with clamped widths
   assign addr     = req_tdata[ADDR_W-1:0];
   assign off      = (cfg.offset_width > OFFSET_MAX) ? OFFSET_MAX : cfg.offset_width;
   assign idw      = (OFFSET_W'(cfg.index_width) > OFFSET_W'(IDX_BOUND)) ?
                     OFFSET_W'(IDX_BOUND) : OFFSET_W'(cfg.index_width);
   assign shifted  = addr >> off;
   assign idx_mask = ~({IDX_W{1'b1}} << idw);
   assign line_in  = IDX_W'(shifted) & idx_mask;
   assign tag_sh   = SH_W'(off) + SH_W'(idw);
   assign tag_in   = addr >> tag_sh;

   assign hit_now  = rd_ff[ADDR_W] && (rd_ff[ADDR_W-1:0] == tag_ff);

   assign status.clear_last = (clr_ff == IDX_W'(MAX_LINES - 1));
   assign status.out_free   = !rsp_tvalid_ff || rsp_tready;

   // Line store: one write port shared by the clearing pass and miss fill
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.commit && !hit_now) begin
         mem[line_ff] <= {1'b1, tag_ff};
      end
      if (cmd.lookup) begin
         rd_ff <= mem[line_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         line_ff <= line_in;
         tag_ff  <= tag_in;
      end
      if (cmd.commit) begin
         out_hit_ff  <= hit_now;
         out_line_ff <= line_ff;
      end
   end

   // Counters advance only at commit, so they double as result fields
   always_ff @(posedge clock) begin
      if (reset) begin
         access_ff     <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            access_ff <= access_ff + 1'b1;
            if (hit_now) begin
               hits_ff <= hits_ff + 1'b1;
            end else begin
               misses_ff <= misses_ff + 1'b1;
            end
         end
         if (cmd.commit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, misses_ff, hits_ff, access_ff,
                        LINE_FIELD_W'(out_line_ff)};

   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      access_ff == (hits_ff + misses_ff))
      else $error("access count differs from hits plus misses");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !cmd.commit)
      else $error("result overwritten while stalled");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (32'(line_ff) < 32'(MAX_LINES)))
      else $error("line index beyond store depth");

   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!cmd.lookup && !cmd.commit))
      else $error("transaction handled during clearing pass");

endmodule

>>> sv/direct_mapped_cache_tag_check.sv
// Top level of the direct-mapped cache tag check.
//
// Usage:
//   req_* carries one 32-bit byte address per transaction. rsp_* returns
//   one result per address: rsp_tuser is the hit flag, rsp_tdata holds the
//   line index and the running access, hit and miss counts (wrapping at
//   2^32). csr_* sets offset_width (address 0) and index_width (address 4);
//   write them only while no transaction is in flight.
// Timing:
//   A result reaches rsp_tvalid via the store read register and the check
//   state; a new address is taken only once the last one is compared. The
//   store is read through a registered port in the accept cycle and compared
//   and filled in the check state, before the next address may use the line.
// Reset:
//   Counters clear and every line of the store is swept, one line per cycle,
//   with req_tready low; configuration writes are taken throughout.
// Stall:
//   A result waits in the output register while rsp_tready is low; the
//   next address is still taken and its result holds until the register
//   frees up.
module direct_mapped_cache_tag_check #(
   parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF,
   parameter int ADDR_BITS = dmc_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // address
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dmc_pkg::ADDR_FIELD_W-1:0]  req_tdata,
   // line_index[9:0], access_count[41:10], hit_count[73:42],
   // miss_count[105:74], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dmc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dmc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dmc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dmc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import dmc_pkg::*;

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   dmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dmc_datapath #(
      .MAX_LINES (MAX_LINES),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
